// File: rtl/core/dsed_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// DLE/STX/ETX deframer package
// Shared widths, codes and the structures that pass between the parser, the
// close-command queue and the frame readout.
// ---------------------------------------------------------------------------
package dsed_pkg;

  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned IDX_W             = 6;
  localparam int unsigned REG_IDX_W         = 2;
  localparam int unsigned PAYLOAD_DEPTH_DEF = 64;
  // Widest count and address over the supported range of payload depths.
  localparam int unsigned CNT_W             = 9;
  localparam int unsigned ADDR_W            = 8;

  localparam logic [REG_IDX_W-1:0] REG_ESCAPE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_START  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_END    = 2'd2;

  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h10;
  localparam logic [BYTE_W-1:0] START_RESET  = 8'h02;
  localparam logic [BYTE_W-1:0] END_RESET    = 8'h03;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    M_IDLE,
    M_ESC,
    M_PAY
  } mode_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SUM,
    B_STAT,
    B_RD,
    B_LOAD
  } back_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] esc;
    logic [BYTE_W-1:0] stx;
    logic [BYTE_W-1:0] etx;
  } codes_t;

  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] count;
    logic             ovf;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic              bank;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } rel_t;

endpackage
`default_nettype wire

// File: rtl/core/dsed_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Close-command queue
// Two-entry queue carrying closed-frame commands from the parser to the
// readout.
// ---------------------------------------------------------------------------
module dsed_queue import dsed_pkg::*; (
  input  wire  clk,
  input  wire  rst,
  input  wire  push,
  input  cmd_t push_cmd,
  output logic full,
  input  wire  pop,
  output logic head_valid,
  output cmd_t head
);

  cmd_t       entry [0:1];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign full       = (fill == 2'd2);
  assign head_valid = (fill != 2'd0);
  assign head       = entry[rptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= !wptr;
      end
      if (do_pop) begin
        rptr <= !rptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/dsed_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Deframer parser
// Accepts received bytes, tracks the escape state, writes payload bytes into
// the current store bank and issues a close command at the end of a frame.
// ---------------------------------------------------------------------------
module dsed_front import dsed_pkg::*; #(
  parameter int unsigned DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire  [BYTE_W-1:0] rx_byte,
  input  codes_t            codes,
  input  wire               q_full,
  output logic              push,
  output cmd_t              cmd,
  output wr_t               wr,
  input  rel_t              rel
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mode_t         mode;
  mode_t         mode_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          ovf;
  logic          ovf_next;
  logic          wbank;
  logic          wbank_next;
  logic [1:0]    busy;
  logic [1:0]    busy_next;
  logic          accept;
  logic          store;

  assign in_ready = !busy[wbank] && !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    mode_next  = mode;
    count_next = count;
    ovf_next   = ovf;
    wbank_next = wbank;
    busy_next  = busy;
    store      = 1'b0;
    push       = 1'b0;
    cmd.bank   = wbank;
    cmd.count  = CNT_W'(count);
    cmd.ovf    = ovf;
    if (rel.en) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (accept) begin
      case (mode)
        M_ESC: begin
          if (rx_byte == codes.esc) begin
            store     = 1'b1;
            mode_next = M_PAY;
          end else if (rx_byte == codes.stx) begin
            count_next = '0;
            ovf_next   = 1'b0;
            mode_next  = M_PAY;
          end else if (rx_byte == codes.etx) begin
            push             = 1'b1;
            count_next       = '0;
            ovf_next         = 1'b0;
            busy_next[wbank] = 1'b1;
            wbank_next       = !wbank;
            mode_next        = M_IDLE;
          end
        end
        M_PAY: begin
          if (rx_byte == codes.esc) begin
            mode_next = M_ESC;
          end else begin
            store = 1'b1;
          end
        end
        default: begin
          mode_next = (rx_byte == codes.esc) ? M_ESC : M_IDLE;
        end
      endcase
    end
    wr.en   = 1'b0;
    wr.bank = wbank;
    wr.addr = ADDR_W'(count[AW-1:0]);
    wr.data = rx_byte;
    if (store) begin
      if (count < CW'(DEPTH)) begin
        wr.en      = 1'b1;
        count_next = count + CW'(1);
      end else begin
        ovf_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= M_IDLE;
      count <= '0;
      ovf   <= 1'b0;
      wbank <= 1'b0;
      busy  <= 2'b00;
    end else begin
      mode  <= mode_next;
      count <= count_next;
      ovf   <= ovf_next;
      wbank <= wbank_next;
      busy  <= busy_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/dsed_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Frame readout
// Holds the two-bank payload store, checks the additive checksum of a closed
// frame and delivers its payload bytes or a single status beat.
// ---------------------------------------------------------------------------
module dsed_back import dsed_pkg::*; #(
  parameter int unsigned DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  wire               clk,
  input  wire               rst,
  input  wr_t               wr,
  input  wire               q_valid,
  input  cmd_t              q_head,
  output logic              pop,
  output rel_t              rel,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [BYTE_W-1:0] data_byte,
  output logic [IDX_W-1:0]  byte_index,
  output logic              has_data,
  output logic [1:0]        frame_status,
  output logic              last
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [BYTE_W-1:0] mem [0:1][0:DEPTH-1];
  logic [BYTE_W-1:0] rdata;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;

  back_state_t       state;
  back_state_t       state_next;
  logic              bank;
  logic              bank_next;
  logic [CW-1:0]     plen;
  logic [CW-1:0]     plen_next;
  logic [CW-1:0]     ptr;
  logic [CW-1:0]     ptr_next;
  logic              issuing;
  logic              issuing_next;
  logic              pend;
  logic              pend_next;
  logic              chk;
  logic              chk_next;
  logic [BYTE_W-1:0] sum;
  logic [BYTE_W-1:0] sum_next;
  status_t           status;
  status_t           status_next;
  logic [CW-1:0]     cnt;
  logic              slot_free;
  logic              ld;
  logic              out_valid_next;
  logic [BYTE_W-1:0] ld_data;
  logic [IDX_W-1:0]  ld_index;
  logic              ld_has;
  status_t           ld_status;
  logic              ld_last;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.bank][wr.addr[AW-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[bank][rd_addr];
    end
  end

  assign cnt       = q_head.count[CW-1:0];
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    bank_next    = bank;
    plen_next    = plen;
    ptr_next     = ptr;
    issuing_next = issuing;
    pend_next    = 1'b0;
    chk_next     = chk;
    sum_next     = sum;
    status_next  = status;
    pop          = 1'b0;
    rel.en       = 1'b0;
    rel.bank     = bank;
    rd_en        = 1'b0;
    rd_addr      = ptr[AW-1:0];
    ld           = 1'b0;
    ld_data      = '0;
    ld_index     = '0;
    ld_has       = 1'b0;
    ld_status    = status;
    ld_last      = 1'b1;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          pop       = 1'b1;
          bank_next = q_head.bank;
          if (q_head.ovf) begin
            status_next = ST_OVERFLOW;
            state_next  = B_STAT;
          end else if (cnt == '0) begin
            status_next = ST_EMPTY;
            state_next  = B_STAT;
          end else begin
            plen_next    = cnt - CW'(1);
            ptr_next     = '0;
            issuing_next = 1'b1;
            sum_next     = '0;
            state_next   = B_SUM;
          end
        end
      end
      B_SUM: begin
        if (issuing) begin
          rd_en     = 1'b1;
          ptr_next  = ptr + CW'(1);
          pend_next = 1'b1;
          chk_next  = (ptr == plen);
          if (ptr == plen) begin
            issuing_next = 1'b0;
          end
        end
        if (pend) begin
          if (chk) begin
            if (sum != rdata) begin
              status_next = ST_MISMATCH;
              state_next  = B_STAT;
            end else if (plen == '0) begin
              status_next = ST_OK;
              state_next  = B_STAT;
            end else begin
              status_next = ST_OK;
              ptr_next    = '0;
              state_next  = B_RD;
            end
          end else begin
            sum_next = sum + rdata;
          end
        end
      end
      B_STAT: begin
        if (slot_free) begin
          ld         = 1'b1;
          rel.en     = 1'b1;
          state_next = B_IDLE;
        end
      end
      B_RD: begin
        rd_en      = 1'b1;
        state_next = B_LOAD;
      end
      B_LOAD: begin
        if (slot_free) begin
          ld       = 1'b1;
          ld_data  = rdata;
          ld_index = IDX_W'(ptr);
          ld_has   = 1'b1;
          ld_last  = (ptr == plen - CW'(1));
          if (ptr == plen - CW'(1)) begin
            rel.en     = 1'b1;
            state_next = B_IDLE;
          end else begin
            ptr_next   = ptr + CW'(1);
            state_next = B_RD;
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
    if (ld) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      data_byte    <= ld_data;
      byte_index   <= ld_index;
      has_data     <= ld_has;
      frame_status <= ld_status;
      last         <= ld_last;
    end
    bank   <= bank_next;
    plen   <= plen_next;
    ptr    <= ptr_next;
    chk    <= chk_next;
    sum    <= sum_next;
    status <= status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      issuing   <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      issuing   <= issuing_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/dle_stx_etx_packet_deframer_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// DLE/STX/ETX packet deframer
// Received bytes enter on the in_valid/in_ready channel, one byte per beat.
// Escape-start opens a frame, a doubled escape stores a literal escape byte
// and escape-end closes it; the last stored byte is an additive checksum.
// A good frame with payload leaves on the out_valid/out_ready channel as one
// beat per payload byte with status ok; any other outcome gives one status beat.
// The user must write the escape, start and end codes through cfg_we/
// cfg_index/cfg_data only while the block is idle; it does not enforce this.
// At a frame close the readout walks its bank of the store: it first sums
// the payload bytes and compares the sum with the checksum byte, then reads
// and delivers the payload bytes one at a time through the single read port
// of the store. The parser carries on into the second bank meanwhile and
// stalls in_ready only when both banks hold frames not yet delivered.
// A stalled receiver holds the output register and, in turn, the readout.
// Reset returns the parser to idle and empties the queue and output; the
// store is not cleared.
// ---------------------------------------------------------------------------
module dle_stx_etx_packet_deframer_core import dsed_pkg::*; #(
  parameter int unsigned PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_we,
  input  wire  [REG_IDX_W-1:0] cfg_index,
  input  wire  [BYTE_W-1:0]    cfg_data,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire  [BYTE_W-1:0]    rx_byte,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [BYTE_W-1:0]    data_byte,
  output logic [IDX_W-1:0]     byte_index,
  output logic                 has_data,
  output logic [1:0]           frame_status,
  output logic                 last
);

  codes_t codes;
  logic   q_full;
  logic   q_valid;
  logic   push;
  logic   pop;
  cmd_t   cmd;
  cmd_t   q_head;
  wr_t    wr;
  rel_t   rel;

  always_ff @(posedge clk) begin
    if (rst) begin
      codes.esc <= ESCAPE_RESET;
      codes.stx <= START_RESET;
      codes.etx <= END_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ESCAPE: codes.esc <= cfg_data;
        REG_START:  codes.stx <= cfg_data;
        REG_END:    codes.etx <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dsed_front #(.DEPTH(PAYLOAD_DEPTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .codes    (codes),
    .q_full   (q_full),
    .push     (push),
    .cmd      (cmd),
    .wr       (wr),
    .rel      (rel)
  );

  dsed_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  dsed_back #(.DEPTH(PAYLOAD_DEPTH)) u_back (
    .clk          (clk),
    .rst          (rst),
    .wr           (wr),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .pop          (pop),
    .rel          (rel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .data_byte    (data_byte),
    .byte_index   (byte_index),
    .has_data     (has_data),
    .frame_status (frame_status),
    .last         (last)
  );

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the DLE/STX/ETX packet deframer core
// Bytes are offered on the input channel, and beats on the output channel are
// checked against a parser held in a scoreboard class. Stimulus begins with
// hand-picked frames, then runs random framed traffic under several code
// settings with random idling on both sides. Along the way the receiver holds
// off for a long stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_top import dsed_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH          = PAYLOAD_DEPTH_DEF;
  localparam int unsigned SETTLE_CYCLES  = 250;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [IDX_W-1:0]  index;
    logic              has_data;
    status_t           status;
    logic              last;
  } beat_t;

  class deframe_scoreboard;
    logic [BYTE_W-1:0] esc = ESCAPE_RESET;
    logic [BYTE_W-1:0] stx = START_RESET;
    logic [BYTE_W-1:0] etx = END_RESET;
    mode_t             mode = M_IDLE;
    int unsigned       fill = 0;
    bit                overrun = 1'b0;
    logic [BYTE_W-1:0] store [DEPTH];
    beat_t             expected_beats [$];
    int unsigned       mismatches = 0;

    function void set_code(logic [REG_IDX_W-1:0] idx, logic [BYTE_W-1:0] value);
      case (idx)
        REG_ESCAPE: esc = value;
        REG_START:  stx = value;
        REG_END:    etx = value;
        default: ;
      endcase
    endfunction

    function void add_beat(logic [BYTE_W-1:0] data, logic [IDX_W-1:0] index,
                           logic has_data, status_t status, logic last);
      beat_t b;
      b.data     = data;
      b.index    = index;
      b.has_data = has_data;
      b.status   = status;
      b.last     = last;
      expected_beats.push_back(b);
    endfunction

    function void keep_byte(logic [BYTE_W-1:0] b);
      if (fill < DEPTH) begin
        store[fill] = b;
        fill++;
      end else begin
        overrun = 1'b1;
      end
    endfunction

    function void close_frame();
      logic [BYTE_W-1:0] sum;
      int unsigned       plen;
      int unsigned       i;
      sum = '0;
      if (overrun) begin
        add_beat('0, '0, 1'b0, ST_OVERFLOW, 1'b1);
      end else if (fill == 0) begin
        add_beat('0, '0, 1'b0, ST_EMPTY, 1'b1);
      end else begin
        plen = fill - 1;
        for (i = 0; i < plen; i++) sum += store[i];
        if (sum != store[plen]) begin
          add_beat('0, '0, 1'b0, ST_MISMATCH, 1'b1);
        end else if (plen == 0) begin
          add_beat('0, '0, 1'b0, ST_OK, 1'b1);
        end else begin
          for (i = 0; i < plen; i++) begin
            add_beat(store[i], IDX_W'(i), 1'b1, ST_OK, i + 1 == plen);
          end
        end
      end
      fill    = 0;
      overrun = 1'b0;
    endfunction

    function void take_rx_byte(logic [BYTE_W-1:0] b);
      case (mode)
        M_ESC: begin
          if (b == esc) begin
            keep_byte(b);
            mode = M_PAY;
          end else if (b == stx) begin
            fill    = 0;
            overrun = 1'b0;
            mode    = M_PAY;
          end else if (b == etx) begin
            close_frame();
            mode = M_IDLE;
          end
        end
        M_PAY: begin
          if (b == esc) mode = M_ESC;
          else keep_byte(b);
        end
        default: mode = (b == esc) ? M_ESC : M_IDLE;
      endcase
    endfunction

    function void compare_field(string name, logic [BYTE_W-1:0] want,
                                logic [BYTE_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_beat(beat_t got);
      beat_t want;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual data %0h index %0d status %0d",
                 $time, got.data, got.index, got.status);
        mismatches++;
        return;
      end
      want = expected_beats.pop_front();
      compare_field("data_byte", want.data, got.data);
      compare_field("byte_index", 8'(want.index), 8'(got.index));
      compare_field("has_data", 8'(want.has_data), 8'(got.has_data));
      compare_field("frame_status", 8'(want.status), 8'(got.status));
      compare_field("last", 8'(want.last), 8'(got.last));
    endfunction

    function int unsigned pending();
      return expected_beats.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    rx_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [BYTE_W-1:0]    data_byte;
  logic [IDX_W-1:0]     byte_index;
  logic                 has_data;
  logic [1:0]           frame_status;
  logic                 last;

  deframe_scoreboard sb;
  beat_t             seen;
  bit                sender_idling = 1'b1;
  bit                ready_idling = 1'b1;
  bit                hold_req = 1'b0;
  int                ready_gap = 0;
  int                rx_count = 0;
  int unsigned       quiet_cycles = 0;

  dle_stx_etx_packet_deframer_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .data_byte    (data_byte),
    .byte_index   (byte_index),
    .has_data     (has_data),
    .frame_status (frame_status),
    .last         (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [BYTE_W-1:0] random_byte();
    return ($urandom_range(0, 5) == 0) ? sb.esc : 8'($urandom_range(0, 255));
  endfunction

  task automatic write_code(input logic [REG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_code(idx, value);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = (sender_idling && $urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.take_rx_byte(b);
    rx_count++;
  endtask

  task automatic send_bytes(input logic [BYTE_W-1:0] seq [$]);
    foreach (seq[k]) send_byte(seq[k]);
  endtask

  // A negative length gives a frame with no bytes at all, not even a checksum.
  task automatic send_frame(input int len, input bit bad_sum, input bit closed);
    logic [BYTE_W-1:0] body [$];
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    int                i;
    sum = '0;
    for (i = 0; i < len; i++) begin
      b = random_byte();
      body.push_back(b);
      sum += b;
    end
    if (len >= 0) body.push_back(bad_sum ? sum + 8'($urandom_range(1, 255)) : sum);
    send_byte(sb.esc);
    send_byte(sb.stx);
    foreach (body[k]) begin
      send_byte(body[k]);
      if (body[k] == sb.esc) send_byte(sb.esc);
    end
    if (closed) begin
      send_byte(sb.esc);
      send_byte(sb.etx);
    end
  endtask

  task automatic random_traffic(input int budget);
    int stop;
    stop = rx_count + budget;
    while (rx_count < stop) begin
      case ($urandom_range(0, 9))
        6: send_frame($urandom_range(1, 8), 1'b1, 1'b1);
        7: send_frame(-1, 1'b0, 1'b1);
        8: repeat ($urandom_range(1, 4)) send_byte(random_byte());
        9: send_frame($urandom_range(0, 5), 1'b0, 1'b0);
        default: send_frame($urandom_range(0, 10), 1'b0, 1'b1);
      endcase
    end
  endtask

  task automatic drain_and_wait();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (ready_gap > 0) begin
        out_ready <= 1'b0;
        ready_gap--;
      end else if (ready_idling && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        ready_gap = $urandom_range(0, 8);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      seen.data     = data_byte;
      seen.index    = byte_index;
      seen.has_data = has_data;
      seen.status   = status_t'(frame_status);
      seen.last     = last;
      sb.check_beat(seen);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    sb = new;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty frame, checksum-only frame, a stuffed escape in the payload, a bad
    // checksum, and an ignored byte after an escape from idle, which keeps the
    // escape pending so that the following escape stores a literal escape.
    send_bytes('{ESCAPE_RESET, START_RESET, ESCAPE_RESET, END_RESET,
                 ESCAPE_RESET, START_RESET, 8'h00, ESCAPE_RESET, END_RESET,
                 ESCAPE_RESET, START_RESET, 8'hFF, ESCAPE_RESET, ESCAPE_RESET, 8'h0F,
                 ESCAPE_RESET, END_RESET,
                 ESCAPE_RESET, START_RESET, 8'h01, 8'h05, ESCAPE_RESET, END_RESET,
                 ESCAPE_RESET, 8'h77, ESCAPE_RESET, ESCAPE_RESET, END_RESET});
    drain_and_wait();
    random_traffic(15);

    // The receiver stops while frames keep coming, so both banks fill up.
    hold_req = 1'b1;
    repeat (3) send_frame($urandom_range(2, 4), 1'b0, 1'b1);
    drain_and_wait();

    write_code(REG_ESCAPE, 8'h00);
    write_code(REG_START, 8'hFF);
    write_code(REG_END, 8'h80);
    write_code(REG_UNUSED, 8'hFF);
    random_traffic(12);
    drain_and_wait();

    write_code(REG_ESCAPE, 8'hFF);
    write_code(REG_START, 8'h00);
    write_code(REG_END, 8'hFE);
    random_traffic(12);
    drain_and_wait();

    // Escape and start share a value, so the escape wins.
    write_code(REG_ESCAPE, 8'h5A);
    write_code(REG_START, 8'h5A);
    write_code(REG_END, 8'hA5);
    random_traffic(8);
    drain_and_wait();

    // Start and end share a value, so no frame can be closed.
    write_code(REG_ESCAPE, 8'h21);
    write_code(REG_START, 8'h42);
    write_code(REG_END, 8'h42);
    random_traffic(5);
    drain_and_wait();

    sender_idling = 1'b0;
    ready_idling  = 1'b0;
    write_code(REG_ESCAPE, ESCAPE_RESET);
    write_code(REG_START, START_RESET);
    write_code(REG_END, END_RESET);
    send_frame(DEPTH, 1'b0, 1'b1);
    drain_and_wait();

    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
